FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define E2Q_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define E2Q_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/e2q_pkg.sv
// Shared constants, types and fixed-point helpers for the Euler angle to quaternion block.
// No dependencies.
package e2q_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int OUT_BITS   = 16;
    localparam int FIELD_W    = 16;
    localparam int PH_W       = 32;
    localparam int PH_SH      = 31 - ANGLE_BITS;

    localparam int SC_STAGES  = 12;
    localparam int CMB_STAGES = 3;
    localparam int NSTAGE     = SC_STAGES + CMB_STAGES;

    typedef logic [29:0]        t_mag;
    typedef logic [30:0]        t_poly;
    typedef logic signed [31:0] t_trig;

    localparam t_poly Q30_ONE     = 31'd1073741824;
    localparam t_poly HALF_PI_Q30 = 31'd1686629713;
    localparam t_mag  OCT_EDGE    = 30'h2000_0000;

    // Exact division by a constant: floor(m / d) = (m * ceil(2^k / d)) >> k,
    // with k = 30 + ceil(log2(d)), holds for every m below 2^30.
    localparam int          K72 = 37;
    localparam logic [31:0] M72 = 32'(((64'd1 << K72) + 64'd71) / 64'd72);
    localparam int          K42 = 36;
    localparam logic [31:0] M42 = 32'(((64'd1 << K42) + 64'd41) / 64'd42);
    localparam int          K20 = 35;
    localparam logic [31:0] M20 = 32'(((64'd1 << K20) + 64'd19) / 64'd20);
    localparam int          K6  = 33;
    localparam logic [31:0] M6  = 32'(((64'd1 << K6) + 64'd5) / 64'd6);
    localparam int          K56 = 36;
    localparam logic [31:0] M56 = 32'(((64'd1 << K56) + 64'd55) / 64'd56);
    localparam int          K30 = 35;
    localparam logic [31:0] M30 = 32'(((64'd1 << K30) + 64'd29) / 64'd30);
    localparam int          K12 = 34;
    localparam logic [31:0] M12 = 32'(((64'd1 << K12) + 64'd11) / 64'd12);

    // Unsigned Q30 product, truncated.
    function automatic t_mag qmul(input t_poly a, input t_poly b);
        logic [61:0] p;
        p = {31'd0, a} * {31'd0, b};
        return p[59:30];
    endfunction

    // Quotient by a constant through its scaled reciprocal.
    function automatic t_mag divc(input t_mag m, input logic [31:0] mr, input int k);
        logic [61:0] p;
        p = {32'd0, m} * {30'd0, mr};
        return t_mag'(p >> k);
    endfunction

    // Signed product brought back to Q30, rounded half up.
    function automatic t_trig rmul_q30(input t_trig a, input t_trig b);
        logic signed [63:0] p;
        p = (64'(a) * 64'(b) + (64'sd1 <<< 29)) >>> 30;
        return 32'(p);
    endfunction

endpackage

FILE: rtl/e2q_sincos.sv
// Pipelined sine and cosine of half a binary angle, Q30, by octant reduction and Horner series.
// Depends on e2q_pkg.
module e2q_sincos (
    input  logic                                   i_clk,
    input  logic [e2q_pkg::SC_STAGES-1:0]          i_en,
    input  logic signed [e2q_pkg::FIELD_W-1:0]     i_angle,
    output e2q_pkg::t_trig                         o_sin,
    output e2q_pkg::t_trig                         o_cos
);

    logic [e2q_pkg::PH_W-1:0] ph;
    logic [29:0]              f;
    logic                     mir;
    e2q_pkg::t_mag            t;

    logic [1:0]    r_quad [0:e2q_pkg::SC_STAGES-2];
    logic          r_mir  [0:e2q_pkg::SC_STAGES-2];
    e2q_pkg::t_mag r_t0;
    e2q_pkg::t_mag r_x1, r_x2_2, r_x3, r_x4, r_x5, r_x6, r_x7, r_x8, r_x9;
    e2q_pkg::t_mag r_xx2, r_xx3, r_xx4, r_xx5, r_xx6, r_xx7;
    e2q_pkg::t_poly r_ps3, r_pc3, r_ps5, r_pc5, r_ps7, r_pc7, r_ps9, r_c9;
    e2q_pkg::t_mag r_ms4, r_mc4, r_ms6, r_mc6, r_ms8, r_mc8;
    e2q_pkg::t_mag  r_s10;
    e2q_pkg::t_poly r_c10;
    e2q_pkg::t_trig r_sin11, r_cos11;
    e2q_pkg::t_trig sv, cv, n_sin, n_cos;

    // The half angle as a phase where 2^32 is one turn.
    always_comb begin
        ph  = e2q_pkg::PH_W'(32'(i_angle)) << e2q_pkg::PH_SH;
        f   = ph[29:0];
        mir = f > e2q_pkg::OCT_EDGE;
        t   = mir ? 30'(e2q_pkg::Q30_ONE - {1'b0, f}) : f;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_quad[0] <= ph[31:30];
            r_mir[0]  <= mir;
            r_t0      <= t;
        end
        for (int k = 1; k < e2q_pkg::SC_STAGES - 1; k++) begin
            if (i_en[k]) begin
                r_quad[k] <= r_quad[k-1];
                r_mir[k]  <= r_mir[k-1];
            end
        end
        if (i_en[1]) begin
            r_x1 <= e2q_pkg::qmul({1'b0, r_t0}, e2q_pkg::HALF_PI_Q30);
        end
        if (i_en[2]) begin
            r_x2_2 <= r_x1;
            r_xx2  <= e2q_pkg::qmul({1'b0, r_x1}, {1'b0, r_x1});
        end
        if (i_en[3]) begin
            r_x3  <= r_x2_2;
            r_xx3 <= r_xx2;
            r_ps3 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_xx2, e2q_pkg::M72, e2q_pkg::K72)};
            r_pc3 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_xx2, e2q_pkg::M56, e2q_pkg::K56)};
        end
        if (i_en[4]) begin
            r_x4  <= r_x3;
            r_xx4 <= r_xx3;
            r_ms4 <= e2q_pkg::qmul({1'b0, r_xx3}, r_ps3);
            r_mc4 <= e2q_pkg::qmul({1'b0, r_xx3}, r_pc3);
        end
        if (i_en[5]) begin
            r_x5  <= r_x4;
            r_xx5 <= r_xx4;
            r_ps5 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_ms4, e2q_pkg::M42, e2q_pkg::K42)};
            r_pc5 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_mc4, e2q_pkg::M30, e2q_pkg::K30)};
        end
        if (i_en[6]) begin
            r_x6  <= r_x5;
            r_xx6 <= r_xx5;
            r_ms6 <= e2q_pkg::qmul({1'b0, r_xx5}, r_ps5);
            r_mc6 <= e2q_pkg::qmul({1'b0, r_xx5}, r_pc5);
        end
        if (i_en[7]) begin
            r_x7  <= r_x6;
            r_xx7 <= r_xx6;
            r_ps7 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_ms6, e2q_pkg::M20, e2q_pkg::K20)};
            r_pc7 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_mc6, e2q_pkg::M12, e2q_pkg::K12)};
        end
        if (i_en[8]) begin
            r_x8  <= r_x7;
            r_ms8 <= e2q_pkg::qmul({1'b0, r_xx7}, r_ps7);
            r_mc8 <= e2q_pkg::qmul({1'b0, r_xx7}, r_pc7);
        end
        if (i_en[9]) begin
            r_x9  <= r_x8;
            r_ps9 <= e2q_pkg::Q30_ONE - {1'b0, e2q_pkg::divc(r_ms8, e2q_pkg::M6, e2q_pkg::K6)};
            r_c9  <= e2q_pkg::Q30_ONE - {2'b0, r_mc8[29:1]};
        end
        if (i_en[10]) begin
            r_s10 <= e2q_pkg::qmul({1'b0, r_x9}, r_ps9);
            r_c10 <= r_c9;
        end
        if (i_en[11]) begin
            r_sin11 <= n_sin;
            r_cos11 <= n_cos;
        end
    end

    // Undo the octant fold, then rotate by the quadrant.
    always_comb begin
        sv = r_mir[e2q_pkg::SC_STAGES-2] ? 32'(r_c10) : 32'({1'b0, r_s10});
        cv = r_mir[e2q_pkg::SC_STAGES-2] ? 32'({1'b0, r_s10}) : 32'(r_c10);
        unique case (r_quad[e2q_pkg::SC_STAGES-2])
            2'd0: begin n_sin = sv;  n_cos = cv;  end
            2'd1: begin n_sin = cv;  n_cos = -sv; end
            2'd2: begin n_sin = -sv; n_cos = -cv; end
            2'd3: begin n_sin = -cv; n_cos = sv;  end
        endcase
    end

    assign o_sin = r_sin11;
    assign o_cos = r_cos11;

endmodule

FILE: rtl/e2q_combine.sv
// Quaternion products of the half-angle sines and cosines, rounded and saturated.
// Depends on e2q_pkg.
module e2q_combine (
    input  logic                                i_clk,
    input  logic [e2q_pkg::CMB_STAGES-1:0]      i_en,
    input  e2q_pkg::t_trig                      i_sh,
    input  e2q_pkg::t_trig                      i_ch,
    input  e2q_pkg::t_trig                      i_sp,
    input  e2q_pkg::t_trig                      i_cp,
    input  e2q_pkg::t_trig                      i_sb,
    input  e2q_pkg::t_trig                      i_cb,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_w,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_x,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_y,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_z
);

    localparam int                 OSH = 61 - e2q_pkg::OUT_BITS;
    localparam logic signed [63:0] HI  = (64'sd1 <<< (e2q_pkg::OUT_BITS - 1)) - 64'sd1;
    localparam logic signed [63:0] LO  = -(64'sd1 <<< (e2q_pkg::OUT_BITS - 1));

    // Round half up to the output scale and clamp to the signed output range.
    function automatic logic [e2q_pkg::FIELD_W-1:0] to_out(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + (64'sd1 <<< (OSH - 1))) >>> OSH;
        if (r > HI) begin
            r = HI;
        end
        if (r < LO) begin
            r = LO;
        end
        return r[e2q_pkg::FIELD_W-1:0];
    endfunction

    e2q_pkg::t_trig r_chcp, r_shsp, r_chsp, r_shcp, r_sb0, r_cb0;
    logic signed [63:0] r_w_a, r_w_b, r_x_a, r_x_b, r_y_a, r_y_b, r_z_a, r_z_b;
    logic [e2q_pkg::FIELD_W-1:0] r_w, r_x, r_y, r_z;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_chcp <= e2q_pkg::rmul_q30(i_ch, i_cp);
            r_shsp <= e2q_pkg::rmul_q30(i_sh, i_sp);
            r_chsp <= e2q_pkg::rmul_q30(i_ch, i_sp);
            r_shcp <= e2q_pkg::rmul_q30(i_sh, i_cp);
            r_sb0  <= i_sb;
            r_cb0  <= i_cb;
        end
        if (i_en[1]) begin
            r_w_a <= 64'(r_chcp) * 64'(r_cb0);
            r_w_b <= 64'(r_shsp) * 64'(r_sb0);
            r_x_a <= 64'(r_chsp) * 64'(r_cb0);
            r_x_b <= 64'(r_shcp) * 64'(r_sb0);
            r_y_a <= 64'(r_shcp) * 64'(r_cb0);
            r_y_b <= 64'(r_chsp) * 64'(r_sb0);
            r_z_a <= 64'(r_chcp) * 64'(r_sb0);
            r_z_b <= 64'(r_shsp) * 64'(r_cb0);
        end
        if (i_en[2]) begin
            r_w <= to_out(r_w_a + r_w_b);
            r_x <= to_out(r_x_a + r_x_b);
            r_y <= to_out(r_y_a - r_y_b);
            r_z <= to_out(r_z_a - r_z_b);
        end
    end

    assign o_quat_w = r_w;
    assign o_quat_x = r_x;
    assign o_quat_y = r_y;
    assign o_quat_z = r_z;

endmodule

FILE: rtl/euler_to_quaternion.sv
// An accepted word passes through the 15 register stages to its result word; each stage
// holds its own word. Throughput: one word per cycle while the output is not stalled.
// A stalled output lets upstream stages fill any empty stage before the input stalls.
// Reset (synchronous, active low) clears the stage valid bits only.
// Depends on e2q_pkg, e2q_sincos and e2q_combine.
module euler_to_quaternion (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [e2q_pkg::FIELD_W-1:0]  i_heading,
    input  logic signed [e2q_pkg::FIELD_W-1:0]  i_pitch,
    input  logic signed [e2q_pkg::FIELD_W-1:0]  i_bank,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_w,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_x,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_y,
    output logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_z
);

    logic [e2q_pkg::NSTAGE-1:0] r_vld;
    logic [e2q_pkg::NSTAGE-1:0] en;
    e2q_pkg::t_trig sh, ch, sp, cp, sb, cb;

    // A stage may load when it is empty or when the stage after it loads too.
    always_comb begin
        en[e2q_pkg::NSTAGE-1] = !r_vld[e2q_pkg::NSTAGE-1] || i_ready;
        for (int k = e2q_pkg::NSTAGE - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < e2q_pkg::NSTAGE; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    e2q_sincos u_sc_heading (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::SC_STAGES-1:0]),
        .i_angle (i_heading),
        .o_sin   (sh),
        .o_cos   (ch)
    );

    e2q_sincos u_sc_pitch (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::SC_STAGES-1:0]),
        .i_angle (i_pitch),
        .o_sin   (sp),
        .o_cos   (cp)
    );

    e2q_sincos u_sc_bank (
        .i_clk   (i_clk),
        .i_en    (en[e2q_pkg::SC_STAGES-1:0]),
        .i_angle (i_bank),
        .o_sin   (sb),
        .o_cos   (cb)
    );

    e2q_combine u_combine (
        .i_clk    (i_clk),
        .i_en     (en[e2q_pkg::NSTAGE-1:e2q_pkg::SC_STAGES]),
        .i_sh     (sh),
        .i_ch     (ch),
        .i_sp     (sp),
        .i_cp     (cp),
        .i_sb     (sb),
        .i_cb     (cb),
        .o_quat_w (o_quat_w),
        .o_quat_x (o_quat_x),
        .o_quat_y (o_quat_y),
        .o_quat_z (o_quat_z)
    );

    assign o_ready = en[0];
    assign o_valid = r_vld[e2q_pkg::NSTAGE-1];

endmodule

FILE: rtl/e2q_chk.sv
// Port-level checks for euler_to_quaternion, attached by bind.
// Depends on assert_macros.svh and e2q_pkg.
`include "assert_macros.svh"

module e2q_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_ready,
    input logic                                o_valid,
    input logic                                i_ready,
    input logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_w,
    input logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_x,
    input logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_y,
    input logic signed [e2q_pkg::FIELD_W-1:0]  o_quat_z
);

    // Nothing comes out in the cycle after reset.
    `E2Q_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "result word after reset")

    // With the output draining, the pipeline always advances to its input.
    `E2Q_ASSERT(a_ready_flow, i_clk, i_rst_n, i_ready |-> o_ready, "input blocked while output drains")

    `E2Q_ASSERT(a_vld_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid, "result word dropped")

    `E2Q_ASSERT(a_data_hold, i_clk, i_rst_n, o_valid && !i_ready |=> $stable(o_quat_w) && $stable(o_quat_x) && $stable(o_quat_y) && $stable(o_quat_z), "stalled result changed")

endmodule

bind euler_to_quaternion e2q_chk u_e2q_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_quat_w (o_quat_w),
    .o_quat_x (o_quat_x),
    .o_quat_y (o_quat_y),
    .o_quat_z (o_quat_z)
);

FILE: test/euler_to_quaternion_tb.sv
// Self-checking testbench for euler_to_quaternion: a directed table, then random angle words
// under several idle and stall patterns, checked against an in-bench fixed-point predictor.
// Depends on e2q_pkg and the euler_to_quaternion RTL.
module euler_to_quaternion_tb;

    localparam int N_RANDOM  = 1900;
    localparam int MAX_CYC   = 600000;
    localparam int HOLD_CYC  = 300;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    typedef struct {
        logic signed [15:0] h;
        logic signed [15:0] p;
        logic signed [15:0] b;
        bit                 typed;
        t_quat              q;
    } t_vec;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_heading = '0;
    logic signed [15:0] i_pitch = '0;
    logic signed [15:0] i_bank = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_quat_w, o_quat_x, o_quat_y, o_quat_z;

    t_quat quat_pending[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_seen = 0;
    int    cycle = 0;
    int    idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_req = 1'b0;

    euler_to_quaternion dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > MAX_CYC) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Sine and cosine in Q30 of a phase where 2^32 is a full turn.
    function automatic void sin_cos_q30(input logic [31:0] ph, output longint s_o,
                                        output longint c_o);
        logic [1:0]       quad;
        logic [63:0]      f, t, x, x2, p, s, c, tmp;
        bit               mirror;
        quad   = ph[31:30];
        f      = {34'd0, ph[29:0]};
        mirror = f > 64'h2000_0000;
        t      = mirror ? (64'h4000_0000 - f) : f;
        x      = (t * 64'd1686629713) >> 30;
        x2     = (x * x) >> 30;
        p = 64'h4000_0000 - x2 / 72;
        p = 64'h4000_0000 - ((x2 * p) >> 30) / 42;
        p = 64'h4000_0000 - ((x2 * p) >> 30) / 20;
        p = 64'h4000_0000 - ((x2 * p) >> 30) / 6;
        s = (x * p) >> 30;
        p = 64'h4000_0000 - x2 / 56;
        p = 64'h4000_0000 - ((x2 * p) >> 30) / 30;
        p = 64'h4000_0000 - ((x2 * p) >> 30) / 12;
        c = 64'h4000_0000 - ((x2 * p) >> 30) / 2;
        if (mirror) begin
            tmp = s;
            s = c;
            c = tmp;
        end
        case (quad)
            2'd0: begin s_o = s;  c_o = c;  end
            2'd1: begin s_o = c;  c_o = -s; end
            2'd2: begin s_o = -s; c_o = -c; end
            default: begin s_o = -c; c_o = s; end
        endcase
    endfunction

    function automatic longint round_q(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic logic signed [15:0] to_q15(input longint v);
        longint r;
        r = round_q(v, 61 - e2q_pkg::OUT_BITS);
        if (r > 32767) r = 32767;
        if (r < -32768) r = -32768;
        return r[15:0];
    endfunction

    function automatic t_quat euler_to_quat(input logic signed [15:0] h,
                                            input logic signed [15:0] p,
                                            input logic signed [15:0] b);
        longint sh, ch, sp, cp, sb, cb, chcp, shsp, chsp, shcp;
        t_quat  q;
        // Halving the angle: the 16-bit angle lands in the top of a 32-bit phase.
        sin_cos_q30({h[15], h, 15'd0}, sh, ch);
        sin_cos_q30({p[15], p, 15'd0}, sp, cp);
        sin_cos_q30({b[15], b, 15'd0}, sb, cb);
        chcp = round_q(ch * cp, 30);
        shsp = round_q(sh * sp, 30);
        chsp = round_q(ch * sp, 30);
        shcp = round_q(sh * cp, 30);
        q.w = to_q15(chcp * cb + shsp * sb);
        q.x = to_q15(chsp * cb + shcp * sb);
        q.y = to_q15(shcp * cb - chsp * sb);
        q.z = to_q15(chcp * sb - shsp * cb);
        return q;
    endfunction

    task automatic report(input string what, input int got, input int want);
        n_errors++;
        $display("mismatch on word %0d: %s got %0d expected %0d", n_seen, what, got, want);
    endtask

    // Offer one word, waiting out the idle pattern first; the expectation is queued
    // at the edge where the word is accepted.
    task automatic send_word(input t_vec v);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_heading <= v.h;
        i_pitch   <= v.p;
        i_bank    <= v.b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        quat_pending.push_back(v.typed ? v.q : euler_to_quat(v.h, v.p, v.b));
        n_sent++;
    endtask

    // Result side: the receiver stalls at random, and once holds off for a long stretch.
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                repeat (HOLD_CYC) begin
                    i_ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_req = 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= stall_pct);
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_quat e;
        if (i_rst_n && o_valid && i_ready) begin
            if (quat_pending.size() == 0) begin
                n_errors++;
                $display("unexpected result word at cycle %0d", cycle);
            end else begin
                e = quat_pending.pop_front();
                if (o_quat_w !== e.w) report("w", o_quat_w, e.w);
                if (o_quat_x !== e.x) report("x", o_quat_x, e.x);
                if (o_quat_y !== e.y) report("y", o_quat_y, e.y);
                if (o_quat_z !== e.z) report("z", o_quat_z, e.z);
            end
            n_seen++;
        end
    end

    function automatic logic signed [15:0] rand_angle();
        case ($urandom_range(9))
            0: return 16'sh8000 + 16'($urandom_range(7));
            1: return 16'sh7FFF - 16'($urandom_range(7));
            2: return 16'($urandom_range(15)) - 16'sd8;
            3: return 16'($urandom_range(3)) << 14;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_vec dir[$];
        t_vec v;
        int   ph;
        // Zero angles give the identity, whose w of exactly one saturates.
        dir.push_back('{16'sd0, 16'sd0, 16'sd0, 1'b1, '{16'sd32767, 16'sd0, 16'sd0, 16'sd0}});
        // A heading of minus half a turn halves to a quarter turn back: y is exactly -1.
        dir.push_back('{-16'sd32768, 16'sd0, 16'sd0, 1'b1,
                        '{16'sd0, 16'sd0, -16'sd32768, 16'sd0}});
        dir.push_back('{16'sd0, -16'sd32768, 16'sd0, 1'b1,
                        '{16'sd0, -16'sd32768, 16'sd0, 16'sd0}});
        dir.push_back('{16'sd0, 16'sd0, -16'sd32768, 1'b1,
                        '{16'sd0, 16'sd0, 16'sd0, -16'sd32768}});
        dir.push_back('{16'sd32767, 16'sd0, 16'sd0, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd32767, 16'sd0, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd0, 16'sd32767, 1'b0, '0});
        dir.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0});
        dir.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0});
        dir.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 1'b0, '0});
        dir.push_back('{-16'sd16384, 16'sd8192, -16'sd8192, 1'b0, '0});
        dir.push_back('{16'sd1, -16'sd1, 16'sd1, 1'b0, '0});
        dir.push_back('{16'sd8192, 16'sd0, 16'sd0, 1'b0, '0});
        dir.push_back('{16'sd0, 16'sd4096, 16'sd12288, 1'b0, '0});
        dir.push_back('{16'sd20000, -16'sd12345, 16'sd30000, 1'b0, '0});
        dir.push_back('{16'sh5555, 16'shAAAA, 16'sh5555, 1'b0, '0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir[k]) send_word(dir[k]);

        for (ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 46; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 46; end
                3: begin idle_pct = 15; stall_pct = 15; end
                default: begin idle_pct = 0; stall_pct = 10; hold_req = 1'b1; end
            endcase
            repeat (N_RANDOM / 5) begin
                v.h = rand_angle();
                v.p = rand_angle();
                v.b = rand_angle();
                v.typed = 1'b0;
                send_word(v);
            end
        end
        i_valid <= 1'b0;

        while (quat_pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("sent %0d angle words (directed table and five idle/stall phases, one long",
                 n_sent);
        $display("receiver hold-off); %0d quaternion words checked", n_seen);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

FILE: sim.f
+incdir+rtl
rtl/e2q_pkg.sv
rtl/e2q_sincos.sv
rtl/e2q_combine.sv
rtl/euler_to_quaternion.sv
rtl/e2q_chk.sv
test/euler_to_quaternion_tb.sv
